>>> sv/hmr_pkg.sv
// Shared types and constants for the HID message reassembler.
// Used by the parser, the result register, the top level and the testbench; depends on nothing.
package hmr_pkg;

    // Report geometry
    localparam int ReportBytes = 64;
    localparam int PosW        = $clog2(ReportBytes);

    // Fixed byte positions inside a report
    localparam logic [PosW-1:0] PosCmd    = PosW'(4);
    localparam logic [PosW-1:0] PosLenHi  = PosW'(5);
    localparam logic [PosW-1:0] PosLenLo  = PosW'(6);
    localparam logic [PosW-1:0] PosLast   = PosW'(ReportBytes - 1);

    localparam logic [31:0] BroadcastChan = 32'hffff_ffff;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_FIRST_NOT_INIT = 2'd0;
    localparam logic [1:0] ERR_UNEXP_INIT     = 2'd1;
    localparam logic [1:0] ERR_SEQ_MISMATCH   = 2'd2;

    // Message phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_CONT = 2'b10
    } t_phase;

    // Handling of the rest of the current report
    typedef enum logic [2:0] {
        RK_DISCARD = 3'b001,
        RK_INIT    = 3'b010,
        RK_CONT    = 3'b100
    } t_rkind;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  error_code;
        logic [31:0] chan;
        logic        broadcast;
        logic [6:0]  command;
        logic [15:0] msg_len;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        last;
        logic [7:0]  packets_used;
    } t_result;

endpackage

>>> sv/hmr_in_reg.sv
// Input register of the reassembler: holds one report byte.
// Depends on nothing; advance is granted by the result register.
module hmr_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_free,
    output logic       o_adv,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Move the held byte on whenever the result side has room
    assign o_adv   = r_valid && i_free;
    assign o_ready = !r_valid || i_free;
    assign o_byte  = r_byte;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the byte on each transaction
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> sv/hmr_parser.sv
// Report parser: position counter, message state and result formation.
// Depends on hmr_pkg for types, positions and codes.
module hmr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output hmr_pkg::t_result o_res
);

    logic [hmr_pkg::PosW-1:0] r_pos, n_pos;
    hmr_pkg::t_phase          r_phase, n_phase;
    hmr_pkg::t_rkind          r_rkind, n_rkind;
    logic [31:0]              r_chan, n_chan;
    logic [31:0]              r_shift, n_shift;
    logic [6:0]               r_cmd, n_cmd;
    logic [15:0]              r_len, n_len;
    logic [15:0]              r_rcv, n_rcv;
    logic [7:0]               r_rpt, n_rpt;

    logic             emit;
    hmr_pkg::t_result res;

    // Next state and result for the byte at the current position
    always_comb begin
        logic        take_payload;
        logic        is_init;
        logic        is_last;
        logic [15:0] len_full;
        take_payload = 1'b0;
        is_init      = i_byte[7];
        is_last      = 1'b0;
        len_full     = {r_len[15:8], i_byte};
        n_pos   = r_pos;
        n_phase = r_phase;
        n_rkind = r_rkind;
        n_chan  = r_chan;
        n_shift = r_shift;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_rcv   = r_rcv;
        n_rpt   = r_rpt;
        emit    = 1'b0;
        res     = '0;
        res.last = 1'b1;

        if (r_pos < hmr_pkg::PosCmd) begin
            // Shift in the channel, most significant byte first
            n_shift = {r_shift[23:0], i_byte};
        end else if (r_pos == hmr_pkg::PosCmd) begin
            res.chan       = r_shift;
            res.command    = i_byte[6:0];
            res.kind       = hmr_pkg::KIND_ERROR;
            if (r_phase == hmr_pkg::PH_IDLE) begin
                if (!is_init) begin
                    emit            = 1'b1;
                    res.error_code  = hmr_pkg::ERR_FIRST_NOT_INIT;
                    n_rkind         = hmr_pkg::RK_DISCARD;
                end else begin
                    n_chan  = r_shift;
                    n_cmd   = i_byte[6:0];
                    n_len   = '0;
                    n_rcv   = '0;
                    n_rpt   = 8'd1;
                    n_rkind = hmr_pkg::RK_INIT;
                end
            end else begin
                res.packets_used = r_rpt;
                if (is_init) begin
                    emit           = 1'b1;
                    res.error_code = hmr_pkg::ERR_UNEXP_INIT;
                    n_phase        = hmr_pkg::PH_IDLE;
                    n_rkind        = hmr_pkg::RK_DISCARD;
                end else if ((r_rpt - 8'd1) != i_byte) begin
                    emit           = 1'b1;
                    res.error_code = hmr_pkg::ERR_SEQ_MISMATCH;
                    n_phase        = hmr_pkg::PH_IDLE;
                    n_rkind        = hmr_pkg::RK_DISCARD;
                end else begin
                    n_rpt   = r_rpt + 8'd1;
                    n_rkind = hmr_pkg::RK_CONT;
                end
            end
        end else if (r_rkind == hmr_pkg::RK_INIT) begin
            if (r_pos == hmr_pkg::PosLenHi) begin
                n_len = {i_byte, 8'h00};
            end else if (r_pos == hmr_pkg::PosLenLo) begin
                n_len = len_full;
                if (len_full == 16'd0) begin
                    // Empty message completes at once
                    emit             = 1'b1;
                    res.kind         = hmr_pkg::KIND_EMPTY;
                    res.chan         = r_chan;
                    res.command      = r_cmd;
                    res.packets_used = r_rpt;
                    n_rkind          = hmr_pkg::RK_DISCARD;
                end else begin
                    n_phase = hmr_pkg::PH_CONT;
                end
            end else begin
                take_payload = 1'b1;
            end
        end else if (r_rkind == hmr_pkg::RK_CONT) begin
            take_payload = 1'b1;
        end

        // Deliver a payload byte, or drop the rest once the message is done
        if (take_payload) begin
            if (r_phase == hmr_pkg::PH_IDLE || r_rcv >= r_len) begin
                n_rkind = hmr_pkg::RK_DISCARD;
            end else begin
                is_last            = (r_rcv + 16'd1) == r_len;
                emit               = 1'b1;
                res.kind           = hmr_pkg::KIND_PAYLOAD;
                res.chan           = r_chan;
                res.command        = r_cmd;
                res.msg_len        = r_len;
                res.data_byte      = i_byte;
                res.byte_index     = r_rcv;
                res.last           = is_last;
                res.packets_used   = r_rpt;
                n_rcv              = r_rcv + 16'd1;
                if (is_last) begin
                    n_phase = hmr_pkg::PH_IDLE;
                    n_rkind = hmr_pkg::RK_DISCARD;
                end
            end
        end

        res.broadcast = (res.chan == hmr_pkg::BroadcastChan);

        // Advance the report position, wrap at the report end
        if (r_pos >= hmr_pkg::PosLast) begin
            n_pos   = '0;
            n_rkind = hmr_pkg::RK_DISCARD;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_res_valid = i_adv && emit;
    assign o_res       = res;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= hmr_pkg::PH_IDLE;
            r_rkind <= hmr_pkg::RK_DISCARD;
            r_rcv   <= '0;
            r_rpt   <= '0;
            r_len   <= '0;
            r_chan  <= '0;
            r_cmd   <= '0;
            r_shift <= '0;
        end else if (i_adv) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_rkind <= n_rkind;
            r_rcv   <= n_rcv;
            r_rpt   <= n_rpt;
            r_len   <= n_len;
            r_chan  <= n_chan;
            r_cmd   <= n_cmd;
            r_shift <= n_shift;
        end
    end

    // No result comes from the channel bytes of a report
    a_no_result_in_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_pos >= hmr_pkg::PosCmd)
        else $error("result raised inside the channel field");

    // An error always drops back to idle
    a_error_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == hmr_pkg::KIND_ERROR |=> r_phase == hmr_pkg::PH_IDLE)
        else $error("phase not idle after error");

    // Payload index stays below the declared length
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == hmr_pkg::KIND_PAYLOAD
            |-> o_res.byte_index < o_res.msg_len)
        else $error("payload index beyond length");

    // Last payload byte ends the message
    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == hmr_pkg::KIND_PAYLOAD && o_res.last
            |=> r_phase == hmr_pkg::PH_IDLE && r_rkind == hmr_pkg::RK_DISCARD)
        else $error("message not closed after last byte");

endmodule

>>> sv/hmr_out_reg.sv
// Result register of the reassembler: holds one result until taken.
// Depends on hmr_pkg for the result type.
module hmr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_res_valid,
    input  hmr_pkg::t_result i_res,
    input  logic             i_tready,
    output logic             o_free,
    output logic             o_tvalid,
    output hmr_pkg::t_result o_res
);

    logic             r_valid;
    hmr_pkg::t_result r_res;

    // Room for a new result when empty or being taken now
    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_res    = r_res;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> sv/hid_message_reassembler_unit.sv
// Top level of the HID message reassembler.
// Depends on hmr_pkg, hmr_in_reg, hmr_parser and hmr_out_reg.
//
//   Channel  Dir  tdata                         tuser  tlast
//   s_axis   in   report byte                   -      -
//   m_axis   out  result fields (96 bits)       kind   last item of message
//
// One report byte is taken per cycle while the output is not stalled. An accepted
// byte sits in the input register, goes through the parser logic and is loaded
// into the result register, from which its result is taken.
// At most one result per byte; bytes that give none still pass through the input register and the parser.
// Reset is synchronous, active low, and returns to position 0, idle.
// A stalled output holds its result while one more byte waits in the input
// register; further input is then held off.
module hid_message_reassembler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] report_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] error_code, [33:2] chan, [34] broadcast, [41:35] command,
    // [57:42] msg_len, [65:58] data_byte, [81:66] byte_index,
    // [89:82] packets_used, [95:90] zero
    output logic [95:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);

    logic             adv;
    logic             free;
    logic [7:0]       byte_q;
    logic             res_valid;
    hmr_pkg::t_result res;
    hmr_pkg::t_result out_res;

    hmr_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_free  (free),
        .o_adv   (adv),
        .o_byte  (byte_q)
    );

    hmr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (byte_q),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hmr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_tready    (m_axis_tready),
        .o_free      (free),
        .o_tvalid    (m_axis_tvalid),
        .o_res       (out_res)
    );

    // Pack the result fields, highest field first
    assign m_axis_tdata = {6'd0,
                           out_res.packets_used,
                           out_res.byte_index,
                           out_res.data_byte,
                           out_res.msg_len,
                           out_res.command,
                           out_res.broadcast,
                           out_res.chan,
                           out_res.error_code};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

>>> test/hid_message_reassembler_unit_tb.sv
// Self-checking testbench for hid_message_reassembler_unit.
// Depends on hmr_pkg and the RTL. Feeds whole HID reports and checks every result
// transaction against a byte-level predictor of the reassembly rules or a hand-typed result.
module hid_message_reassembler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit  = 400_000;
    localparam int RandomBytes = 400;

    // One row of the directed plan: a report, optionally repeated, with an optional
    // hand-typed result at its command byte (errors) or length low byte (empty message)
    typedef struct {
        logic [31:0]      chan;
        logic [7:0]       hdr;
        logic [15:0]      len;
        int               reps;
        bit               auto_seq;
        bit               typed;
        hmr_pkg::t_result want;
    } t_report_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] report_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // error_code, chan, broadcast, command, ...
    logic [1:0]  m_axis_tuser;         // [1:0] kind
    logic        m_axis_tlast;

    // Predictor state
    logic [hmr_pkg::PosW-1:0] pos_q;
    hmr_pkg::t_phase          phase_q;
    hmr_pkg::t_rkind          rkind_q;
    logic [31:0]              chan_q;
    logic [31:0]              chan_shift_q;
    logic [6:0]               cmd_q;
    logic [15:0]              len_q;
    logic [15:0]              rcvd_q;
    logic [7:0]               rpt_cnt_q;

    hmr_pkg::t_result pending_results[$];
    t_report_row      plan[$];

    int gap_pct      = 0;
    int stall_pct    = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int bytes_sent   = 0;
    int reports_sent = 0;
    int payload_cnt  = 0;
    int empty_cnt    = 0;
    int err_item_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    hid_message_reassembler_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic hmr_pkg::t_result mk_result(
        input logic [1:0] kind, input logic [1:0] code,
        input logic [31:0] chan, input logic [6:0] cmd,
        input logic [15:0] len, input logic [7:0] data,
        input logic [15:0] idx, input logic last,
        input logic [7:0] pk);
        hmr_pkg::t_result r;
        r.kind           = kind;
        r.error_code     = code;
        r.chan           = chan;
        r.broadcast      = (chan == hmr_pkg::BroadcastChan);
        r.command        = cmd;
        r.msg_len        = len;
        r.data_byte      = data;
        r.byte_index     = idx;
        r.last           = last;
        r.packets_used   = pk;
        return r;
    endfunction

    // Advance the predictor by one report byte; return 1 when the byte yields a result.
    // The error field reads zero on payload and completion items.
    function automatic bit reassemble_byte(input logic [7:0] b, output hmr_pkg::t_result r);
        bit fire;
        bit fin;
        fire = 1'b0;
        r    = '0;
        if (pos_q < hmr_pkg::PosCmd) begin
            chan_shift_q = {chan_shift_q[23:0], b};
        end else if (pos_q == hmr_pkg::PosCmd) begin
            if (phase_q == hmr_pkg::PH_IDLE && !b[7]) begin
                r = mk_result(hmr_pkg::KIND_ERROR, hmr_pkg::ERR_FIRST_NOT_INIT,
                              chan_shift_q, b[6:0], '0, '0, '0, 1'b1, '0);
                rkind_q = hmr_pkg::RK_DISCARD;
                fire    = 1'b1;
            end else if (phase_q == hmr_pkg::PH_IDLE) begin
                chan_q    = chan_shift_q;
                cmd_q     = b[6:0];
                len_q     = '0;
                rcvd_q    = '0;
                rpt_cnt_q = 8'd1;
                rkind_q   = hmr_pkg::RK_INIT;
            end else if (b[7] || b != rpt_cnt_q - 8'd1) begin
                r = mk_result(hmr_pkg::KIND_ERROR,
                              b[7] ? hmr_pkg::ERR_UNEXP_INIT : hmr_pkg::ERR_SEQ_MISMATCH,
                              chan_shift_q, b[6:0], '0, '0, '0, 1'b1, rpt_cnt_q);
                phase_q = hmr_pkg::PH_IDLE;
                rkind_q = hmr_pkg::RK_DISCARD;
                fire    = 1'b1;
            end else begin
                rpt_cnt_q = rpt_cnt_q + 8'd1;
                rkind_q   = hmr_pkg::RK_CONT;
            end
        end else if (rkind_q == hmr_pkg::RK_INIT && pos_q == hmr_pkg::PosLenHi) begin
            len_q = {b, 8'h00};
        end else if (rkind_q == hmr_pkg::RK_INIT && pos_q == hmr_pkg::PosLenLo) begin
            len_q[7:0] = b;
            if (len_q == '0) begin
                r = mk_result(hmr_pkg::KIND_EMPTY, '0, chan_q, cmd_q, '0, '0, '0, 1'b1,
                              rpt_cnt_q);
                rkind_q = hmr_pkg::RK_DISCARD;
                fire    = 1'b1;
            end else begin
                phase_q = hmr_pkg::PH_CONT;
            end
        end else if (rkind_q != hmr_pkg::RK_DISCARD) begin
            // payload byte of an init or continuation report
            if (phase_q == hmr_pkg::PH_IDLE || rcvd_q >= len_q) begin
                rkind_q = hmr_pkg::RK_DISCARD;
            end else begin
                fin = (rcvd_q + 16'd1 == len_q);
                r = mk_result(hmr_pkg::KIND_PAYLOAD, '0, chan_q, cmd_q, len_q, b, rcvd_q,
                              fin, rpt_cnt_q);
                rcvd_q = rcvd_q + 16'd1;
                fire   = 1'b1;
                if (fin) begin
                    phase_q = hmr_pkg::PH_IDLE;
                    rkind_q = hmr_pkg::RK_DISCARD;
                end
            end
        end
        // wrap the report position
        if (pos_q >= hmr_pkg::PosLast) begin
            pos_q   = '0;
            rkind_q = hmr_pkg::RK_DISCARD;
        end else begin
            pos_q = pos_q + 1'b1;
        end
        return fire;
    endfunction

    function automatic void add_row(input logic [31:0] chan, input logic [7:0] hdr,
                                    input logic [15:0] len, input int reps,
                                    input bit auto_seq, input bit typed,
                                    input hmr_pkg::t_result want);
        t_report_row row;
        row.chan     = chan;
        row.hdr      = hdr;
        row.len      = len;
        row.reps     = reps;
        row.auto_seq = auto_seq;
        row.typed    = typed;
        row.want     = want;
        plan.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic cmp_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Unpack the result transaction and compare it with the oldest expectation
    task automatic check_result();
        hmr_pkg::t_result got;
        hmr_pkg::t_result want;
        got.kind           = m_axis_tuser;
        got.error_code     = m_axis_tdata[1:0];
        got.chan           = m_axis_tdata[33:2];
        got.broadcast      = m_axis_tdata[34];
        got.command        = m_axis_tdata[41:35];
        got.msg_len        = m_axis_tdata[57:42];
        got.data_byte      = m_axis_tdata[65:58];
        got.byte_index     = m_axis_tdata[81:66];
        got.last           = m_axis_tlast;
        got.packets_used   = m_axis_tdata[89:82];
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, kind", got.kind, '0);
        end else begin
            want = pending_results.pop_front();
            cmp_field("kind", got.kind, want.kind);
            cmp_field("error_code", got.error_code, want.error_code);
            cmp_field("chan", got.chan, want.chan);
            cmp_field("broadcast", got.broadcast, want.broadcast);
            cmp_field("command", got.command, want.command);
            cmp_field("msg_len", got.msg_len, want.msg_len);
            cmp_field("data_byte", got.data_byte, want.data_byte);
            cmp_field("byte_index", got.byte_index, want.byte_index);
            cmp_field("last", got.last, want.last);
            cmp_field("packets_used", got.packets_used, want.packets_used);
            unique case (want.kind)
                hmr_pkg::KIND_PAYLOAD: payload_cnt++;
                hmr_pkg::KIND_EMPTY:   empty_cnt++;
                default:               err_item_cnt++;
            endcase
        end
    endtask

    // Drive one byte with random source gaps; predict it once the transaction completes
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input hmr_pkg::t_result want);
        hmr_pkg::t_result r;
        bit               fire;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        fire = reassemble_byte(b, r);
        if (typed)
            pending_results.push_back(want);
        else if (fire)
            pending_results.push_back(r);
        bytes_sent++;
    endtask

    // Send one full report; length bytes only matter for init headers
    task automatic send_report(input logic [31:0] chan, input logic [7:0] hdr,
                               input logic [15:0] len, input bit typed,
                               input hmr_pkg::t_result want);
        logic [7:0] b;
        int         typed_at;
        typed_at = (want.kind == hmr_pkg::KIND_ERROR) ? hmr_pkg::PosCmd : hmr_pkg::PosLenLo;
        for (int i = 0; i < hmr_pkg::ReportBytes; i++) begin
            b = 8'($urandom);
            if (i < 4)
                b = chan[31 - 8*i -: 8];
            else if (i == hmr_pkg::PosCmd)
                b = hdr;
            else if (hdr[7] && i == hmr_pkg::PosLenHi)
                b = len[15:8];
            else if (hdr[7] && i == hmr_pkg::PosLenLo)
                b = len[7:0];
            send_byte(b, typed && i == typed_at, want);
        end
        reports_sent++;
    endtask

    // A well-formed message with random content, now and then broken part way
    task automatic send_message();
        logic [31:0] chan;
        logic [15:0] len;
        int          sel;
        int          conts;
        int          brk;
        case ($urandom_range(7))
            0:       chan = hmr_pkg::BroadcastChan;
            1:       chan = '0;
            default: chan = $urandom;
        endcase
        sel = $urandom_range(7);
        if (sel == 0)
            len = '0;
        else if (sel < 6)
            len = 16'($urandom_range(60, 1));
        else
            len = 16'($urandom_range(240, 61));
        conts = (len > 57) ? (len - 57 + 58) / 59 : 0;
        brk   = ($urandom_range(99) < 15) ? int'($urandom_range(conts)) : -1;
        send_report(chan, {1'b1, 7'($urandom)}, len, 1'b0, '0);
        for (int n = 0; n <= conts; n++) begin
            if (n == brk) begin
                // inject an init header or a sequence byte with one bit flipped
                if ($urandom_range(1))
                    send_report(chan, {1'b1, 7'($urandom)}, 16'($urandom), 1'b0, '0);
                else
                    send_report(chan, (rpt_cnt_q - 8'd1) ^ 8'(1 << $urandom_range(6)),
                                '0, 1'b0, '0);
                break;
            end
            if (n < conts)
                send_report(chan, rpt_cnt_q - 8'd1, '0, 1'b0, '0);
        end
    endtask

    // Hold the source off until every pending result has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Sink: check completed result transactions, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int target;

        pos_q        = '0;
        phase_q      = hmr_pkg::PH_IDLE;
        rkind_q      = hmr_pkg::RK_DISCARD;
        chan_q       = '0;
        chan_shift_q = '0;
        cmd_q        = '0;
        len_q        = '0;
        rcvd_q       = '0;
        rpt_cnt_q    = '0;

        // continuation right after reset
        add_row(32'h0000_0000, 8'h00, '0, 1, 1'b0, 1'b1,
                mk_result(hmr_pkg::KIND_ERROR, hmr_pkg::ERR_FIRST_NOT_INIT, 32'h0000_0000,
                          7'h00, '0, '0, '0, 1'b1, 8'd0));
        // empty message on the broadcast channel, top command value
        add_row(hmr_pkg::BroadcastChan, 8'hff, 16'd0, 1, 1'b0, 1'b1,
                mk_result(hmr_pkg::KIND_EMPTY, '0, hmr_pkg::BroadcastChan, 7'h7f,
                          '0, '0, '0, 1'b1, 8'd1));
        // short message inside the init report
        add_row(32'h1234_5678, 8'h86, 16'd3, 1, 1'b0, 1'b0, '0);
        // message spanning two continuations
        add_row(32'hdead_beef, 8'h90, 16'd120, 1, 1'b0, 1'b0, '0);
        add_row(32'hdead_beef, 8'h00, '0, 2, 1'b1, 1'b0, '0);
        // init where a continuation is due
        add_row(32'ha5a5_a5a5, 8'hc1, 16'd200, 1, 1'b0, 1'b0, '0);
        add_row(32'h0000_0001, 8'h81, 16'd5, 1, 1'b0, 1'b1,
                mk_result(hmr_pkg::KIND_ERROR, hmr_pkg::ERR_UNEXP_INIT, 32'h0000_0001,
                          7'h01, '0, '0, '0, 1'b1, 8'd1));
        // wrong sequence byte
        add_row(32'h8000_0000, 8'h82, 16'd200, 1, 1'b0, 1'b0, '0);
        add_row(32'h8000_0000, 8'h05, '0, 1, 1'b0, 1'b1,
                mk_result(hmr_pkg::KIND_ERROR, hmr_pkg::ERR_SEQ_MISMATCH, 32'h8000_0000,
                          7'h05, '0, '0, '0, 1'b1, 8'd1));
        // one-byte message, then a continuation after the message has ended
        add_row(32'h00ff_00ff, 8'h80, 16'd1, 1, 1'b0, 1'b0, '0);
        add_row(32'h00ff_00ff, 8'h00, '0, 1, 1'b0, 1'b1,
                mk_result(hmr_pkg::KIND_ERROR, hmr_pkg::ERR_FIRST_NOT_INIT, 32'h00ff_00ff,
                          7'h00, '0, '0, '0, 1'b1, 8'd0));
        // longest length, cut short by an init header after two continuations
        add_row(32'h7fff_ffff, 8'h83, 16'hffff, 1, 1'b0, 1'b0, '0);
        add_row(32'h7fff_ffff, 8'h00, '0, 2, 1'b1, 1'b0, '0);
        add_row(32'h7fff_ffff, 8'h80, '0, 1, 1'b0, 1'b1,
                mk_result(hmr_pkg::KIND_ERROR, hmr_pkg::ERR_UNEXP_INIT, 32'h7fff_ffff,
                          7'h00, '0, '0, '0, 1'b1, 8'd3));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan, no idling
        foreach (plan[k])
            for (int n = 0; n < plan[k].reps; n++)
                send_report(plan[k].chan, plan[k].auto_seq ? rpt_cnt_q - 8'd1 : plan[k].hdr,
                            plan[k].len, plan[k].typed, plan[k].want);
        drain();

        // Random traffic under four gap/stall mixes, draining between them
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 67; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 67; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            target = bytes_sent + RandomBytes / 4;
            while (bytes_sent < target) begin
                if ($urandom_range(4) == 0)
                    send_report($urandom, 8'($urandom), 16'($urandom), 1'b0, '0);
                else
                    send_message();
            end
            drain();
        end

        stall_pct = 0;
        repeat (10) @(posedge i_clk);

        $display("Drove %0d report bytes in %0d reports, directed then random",
                 bytes_sent, reports_sent);
        $display("under four gap/stall mixes; checked %0d payload, %0d empty-message",
                 payload_cnt, empty_cnt);
        $display("and %0d error results; %0d mismatches.", err_item_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
